FILE: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Shared constants, widths and codes for the pattern search core.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Largest pattern that the core holds.
  localparam int PATTERN_MAX = 64;

  // Index into the pattern store and window.
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  // Effective pattern length, 1 to PATTERN_MAX.
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  // Field widths of the transactions.
  localparam int ENTRY_IDX_W = 6;
  localparam int BYTE_W      = 8;
  localparam int OFFSET_W    = 32;
  localparam int CFG_LEN_W   = 7;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes (byte address divided by four).
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  // Input operation codes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] byte_vec_t;
  typedef logic [PATTERN_MAX-1:0]             bit_vec_t;

endpackage

FILE: rtl/wbps_if.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search channels
// Valid/ready channels for input items and search results.
// ----------------------------------------------------------------------------
interface wbps_in_if import wbps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  op_t                    op;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [BYTE_W-1:0]      entry_value;
  logic                   entry_wildcard;
  logic [BYTE_W-1:0]      data_byte;
  logic                   region_start;
  logic                   region_end;

  modport source (
    output valid, op, entry_index, entry_value, entry_wildcard, data_byte,
           region_start, region_end,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, entry_value, entry_wildcard, data_byte,
           region_start, region_end,
    output ready
  );
endinterface

interface wbps_out_if import wbps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

FILE: rtl/wbps_match.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search window compare
// Aligns the byte window to the pattern and compares all positions at once.
// ----------------------------------------------------------------------------
module wbps_match import wbps_pkg::*; (
  input  byte_vec_t        window,
  input  byte_vec_t        pattern,
  input  bit_vec_t         wild,
  input  logic [LEN_W-1:0] len,
  output logic             match
);

  byte_vec_t        rev;
  byte_vec_t        aligned;
  logic [IDX_W-1:0] shift;
  bit_vec_t         hit;

  // Reverse the window so that the newest byte sits at the top.
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      rev[j] = window[PATTERN_MAX-1-j];
    end
  end

  // Pattern position p must see the byte that arrived len-1-p bytes ago.
  assign shift   = IDX_W'(LEN_W'(PATTERN_MAX) - len);
  assign aligned = rev >> {shift, 3'b000};

  // Positions past the length and wildcard positions always hit.
  always_comb begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      hit[p] = (LEN_W'(p) >= len) || wild[p] || (aligned[p] == pattern[p]);
    end
  end

  assign match = &hit;

endmodule

FILE: rtl/wildcard_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern search core
// A transaction is taken into the input register and, when the pipe advances,
// is processed into the result register, from which its result is offered.
// Throughput: one transaction per cycle while the result side does not stall;
// a parallel comparator bank behind the input register does the full window compare.
// Reset: synchronous, active low; clears the region count, done and valid flags
// and sets length to 1. The pattern store and window are undefined until written.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wbps_in_if.sink               in_ch,
  wbps_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Configuration register.
  logic [CFG_LEN_W-1:0] len_cfg_r;

  // Input register stage.
  logic                   s1_valid_r;
  op_t                    s1_op_r;
  logic [ENTRY_IDX_W-1:0] s1_idx_r;
  logic [BYTE_W-1:0]      s1_val_r;
  logic                   s1_wild_r;
  logic [BYTE_W-1:0]      s1_data_r;
  logic                   s1_start_r;
  logic                   s1_end_r;

  // Search state.
  byte_vec_t           win_r;
  byte_vec_t           win_nxt;
  byte_vec_t           pat_r;
  bit_vec_t            wild_r;
  logic [OFFSET_W-1:0] seen_r;
  logic [OFFSET_W-1:0] seen_base;
  logic [OFFSET_W-1:0] seen_nxt;
  logic                done_r;
  logic                done_base;

  // Result register.
  logic                out_valid_r;
  logic                out_found_r;
  logic [OFFSET_W-1:0] out_offset_r;

  logic                advance;
  logic                proc;
  logic                data_live;
  logic [LEN_W-1:0]    eff_len;
  logic                win_match;
  logic                hit;
  logic                res_valid;

  // Configuration port: writes complete in the access phase.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= CFG_LEN_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[CFG_ADDR_W-1] == REG_PATTERN_LENGTH)) begin
      len_cfg_r <= cfg_pwdata[CFG_LEN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_PATTERN_LENGTH) begin
      cfg_prdata = CFG_DATA_W'(len_cfg_r);
    end
  end

  // Length in use, clamped to 1..PATTERN_MAX.
  always_comb begin
    if (len_cfg_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_cfg_r) > PATTERN_MAX) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = LEN_W'(len_cfg_r);
    end
  end

  // Pipeline flow: the whole pipe moves when the result slot is free.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign proc         = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r    <= in_ch.op;
      s1_idx_r   <= in_ch.entry_index;
      s1_val_r   <= in_ch.entry_value;
      s1_wild_r  <= in_ch.entry_wildcard;
      s1_data_r  <= in_ch.data_byte;
      s1_start_r <= in_ch.region_start;
      s1_end_r   <= in_ch.region_end;
    end
  end

  // Region start restarts the count and reopens the region.
  assign seen_base = s1_start_r ? '0 : seen_r;
  assign done_base = s1_start_r ? 1'b0 : done_r;
  assign data_live = (s1_op_r == OP_DATA) && !done_base;

  // Next window and saturating byte count.
  assign win_nxt  = {win_r[PATTERN_MAX-2:0], s1_data_r};
  assign seen_nxt = (seen_base == '1) ? seen_base : seen_base + OFFSET_W'(1);

  wbps_match u_match (
    .window  (win_nxt),
    .pattern (pat_r),
    .wild    (wild_r),
    .len     (eff_len),
    .match   (win_match)
  );

  assign hit       = (seen_nxt >= OFFSET_W'(eff_len)) && win_match;
  assign res_valid = data_live && (hit || s1_end_r);

  // Pattern store: written by load transactions.
  always_ff @(posedge clk) begin
    if (proc && (s1_op_r == OP_LOAD) && (32'(s1_idx_r) < PATTERN_MAX)) begin
      pat_r[IDX_W'(s1_idx_r)]  <= s1_val_r;
      wild_r[IDX_W'(s1_idx_r)] <= s1_wild_r;
    end
  end

  // Window shift line; only bytes of the current region are ever compared.
  always_ff @(posedge clk) begin
    if (proc && data_live) begin
      win_r <= win_nxt;
    end
  end

  // Region count and done flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
    end else if (proc && (s1_op_r == OP_DATA)) begin
      if (done_base) begin
        seen_r <= seen_base;
        done_r <= done_base;
      end else begin
        seen_r <= seen_nxt;
        done_r <= res_valid;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_found_r  <= hit;
      out_offset_r <= hit ? (seen_nxt - OFFSET_W'(eff_len)) : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.match_offset = out_offset_r;

endmodule

FILE: tb/sv/wbps_search_checker.sv
// ----------------------------------------------------------------------------
// Pattern search result checker
// Watches the input, result and configuration ports of the search core. It
// keeps its own copy of the window, pattern store and region state, predicts
// the result that each accepted transaction causes, if any, and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wbps_search_checker import wbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wbps_in_if                    in_mon,
  wbps_out_if                   out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    mismatches,
  output int                    pending_results
);

  localparam logic [CFG_ADDR_W-1:0] LENGTH_ADDR = CFG_ADDR_W'(REG_PATTERN_LENGTH) << 2;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } search_result_t;

  // Search state mirrored from the core.
  logic [BYTE_W-1:0]    recent_bytes [PATTERN_MAX];
  logic [BYTE_W-1:0]    pat_byte [PATTERN_MAX];
  logic                 pat_any [PATTERN_MAX];
  logic [OFFSET_W-1:0]  seen_count;
  logic                 region_closed;
  logic [CFG_LEN_W-1:0] length_reg;
  search_result_t       awaited_results [$];

  // Apply one accepted input transaction and queue the result it causes.
  task automatic predict_search(input op_t op, input logic [ENTRY_IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] val, input logic wild,
                                input logic [BYTE_W-1:0] data, input logic start,
                                input logic last);
    int n;
    bit hit;
    search_result_t res;
    if (op == OP_LOAD) begin
      pat_byte[idx] = val;
      pat_any[idx]  = wild;
      return;
    end
    if (start) begin
      foreach (recent_bytes[k]) recent_bytes[k] = '0;
      seen_count    = '0;
      region_closed = 1'b0;
    end
    if (region_closed) return;

    // Newest byte sits at position zero of the window.
    for (int k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = data;
    if (seen_count != '1) seen_count++;

    n = int'(length_reg);
    if (n < 1) n = 1;
    if (n > PATTERN_MAX) n = PATTERN_MAX;

    hit = (seen_count >= OFFSET_W'(n));
    for (int k = 0; k < n; k++) begin
      if (!pat_any[n-1-k] && recent_bytes[k] != pat_byte[n-1-k]) hit = 1'b0;
    end

    if (hit) begin
      res.found  = 1'b1;
      res.offset = seen_count - OFFSET_W'(n);
      awaited_results.push_back(res);
      region_closed = 1'b1;
    end else if (last) begin
      res.found  = 1'b0;
      res.offset = '0;
      awaited_results.push_back(res);
      region_closed = 1'b1;
    end
  endtask

  // Compare results first: a result never belongs to a transaction taken at
  // the same edge.
  always @(posedge clk) begin : monitor
    search_result_t want;
    if (!rst_n) begin
      foreach (recent_bytes[k]) recent_bytes[k] = '0;
      seen_count      = '0;
      region_closed   = 1'b0;
      length_reg      = CFG_LEN_W'(1);
      mismatches      = 0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual found=%0b offset=%0d",
                   $time, out_mon.found, out_mon.match_offset);
        end else begin
          want = awaited_results.pop_front();
          if (out_mon.found !== want.found) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, out_mon.found);
          end
          if (out_mon.match_offset !== want.offset) begin
            mismatches++;
            $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                     $time, want.offset, out_mon.match_offset);
          end
        end
      end

      // Register writes land at the access phase.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == LENGTH_ADDR) begin
        length_reg = cfg_pwdata[CFG_LEN_W-1:0];
      end

      if (in_mon.valid && in_mon.ready) begin
        predict_search(in_mon.op, in_mon.entry_index, in_mon.entry_value,
                       in_mon.entry_wildcard, in_mon.data_byte, in_mon.region_start,
                       in_mon.region_end);
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Pattern search core testbench
// Drives pattern loads, region bytes and length settings into the search
// core under several idling patterns, with a directed opening and a long
// random part of planted, random, short and broken regions. The checker
// beside the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import wbps_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam logic [CFG_ADDR_W-1:0] LENGTH_ADDR = CFG_ADDR_W'(REG_PATTERN_LENGTH) << 2;

  typedef struct {
    op_t                    op;
    logic [ENTRY_IDX_W-1:0] index;
    logic [BYTE_W-1:0]      value;
    logic                   wild;
    logic [BYTE_W-1:0]      data;
    logic                   start;
    logic                   last;
  } search_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    fail_count;
  int                    pending_results;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    sent_items;

  // Copy of the loaded pattern, used to plant matches in regions.
  logic [BYTE_W-1:0]     pat_mirror [PATTERN_MAX];
  logic                  wild_mirror [PATTERN_MAX];

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_search_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  wbps_search_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatches      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #6000000;
    $display("wildcard_byte_pattern_search_core test failed");
    $finish;
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one transaction after an optional random gap.
  task automatic drive_item(input search_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.entry_index    <= it.index;
    in_ch.entry_value    <= it.value;
    in_ch.entry_wildcard <= it.wild;
    in_ch.data_byte      <= it.data;
    in_ch.region_start   <= it.start;
    in_ch.region_end     <= it.last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    sent_items++;
  endtask

  // Pattern load; the region fields carry noise.
  task automatic load_entry(input logic [ENTRY_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                            input logic wild);
    search_item_t it;
    it.op    = OP_LOAD;
    it.index = idx;
    it.value = val;
    it.wild  = wild;
    it.data  = BYTE_W'($urandom);
    it.start = 1'($urandom);
    it.last  = 1'($urandom);
    pat_mirror[idx]  = val;
    wild_mirror[idx] = wild;
    drive_item(it);
  endtask

  // Region byte; the load fields carry noise.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic s, input logic e);
    search_item_t it;
    it.op    = OP_DATA;
    it.index = ENTRY_IDX_W'($urandom);
    it.value = BYTE_W'($urandom);
    it.wild  = 1'($urandom);
    it.data  = b;
    it.start = s;
    it.last  = e;
    drive_item(it);
  endtask

  // Drain all results and let the pipeline empty before touching registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_length(input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= LENGTH_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic int effective_length(input int value);
    if (value < 1) return 1;
    if (value > PATTERN_MAX) return PATTERN_MAX;
    return value;
  endfunction

  task automatic load_pattern(input int n, input int wild_pct);
    for (int i = 0; i < n; i++) begin
      load_entry(ENTRY_IDX_W'(i), BYTE_W'($urandom), $urandom_range(99) < wild_pct);
    end
  endtask

  // One region: a planted match, random bytes drawn mostly from the pattern,
  // a region no longer than the pattern, or a random one that may miss its start or end mark.
  task automatic run_region(input int n);
    int kind;
    int total;
    int pre;
    bit drop_start;
    bit drop_end;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(99);
    pre = 0;
    if (kind < 55) begin
      pre = $urandom_range(0, n + 3);
      total = pre + n + $urandom_range(0, 3);
    end else if (kind < 90 && kind >= 80) begin
      total = $urandom_range(1, n);
    end else begin
      total = $urandom_range(1, 2 * n + 4);
    end
    drop_start = (kind >= 90) && ($urandom_range(1) == 0);
    drop_end   = (kind >= 90) && ($urandom_range(1) == 0);
    for (int k = 0; k < total; k++) begin
      if (kind < 55 && k >= pre && k < pre + n) begin
        b = wild_mirror[k-pre] ? BYTE_W'($urandom) : pat_mirror[k-pre];
      end else if ($urandom_range(3) == 0) begin
        b = BYTE_W'($urandom);
      end else begin
        b = pat_mirror[$urandom_range(n - 1)];
      end
      // An occasional pattern rewrite in the middle of a region.
      if ($urandom_range(99) < 3) begin
        load_entry(ENTRY_IDX_W'($urandom), BYTE_W'($urandom), $urandom_range(3) == 0);
      end
      push_byte(b, (k == 0) && !drop_start, (k == total - 1) && !drop_end);
    end
  endtask

  initial begin
    int len;
    int n;
    int phase;
    rst_n                = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_LOAD;
    in_ch.entry_index    = '0;
    in_ch.entry_value    = '0;
    in_ch.entry_wildcard = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.region_start   = 1'b0;
    in_ch.region_end     = 1'b0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    sent_items           = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Length one from reset: bytes before any start mark, a match, bytes
    // ignored after it, then one-byte regions with and without a match.
    load_entry(ENTRY_IDX_W'(0), 8'hFF, 1'b0);
    load_entry(ENTRY_IDX_W'(PATTERN_MAX - 1), 8'h00, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h12, 1'b1, 1'b1);

    // Three-byte pattern with a wildcard in the middle: a region too short
    // to match, then a match one byte in.
    settle();
    write_length(3);
    load_entry(ENTRY_IDX_W'(0), 8'h41, 1'b0);
    load_entry(ENTRY_IDX_W'(1), 8'h00, 1'b1);
    load_entry(ENTRY_IDX_W'(2), 8'h43, 1'b0);
    push_byte(8'h41, 1'b1, 1'b0);
    push_byte(8'h42, 1'b0, 1'b1);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h41, 1'b0, 1'b0);
    push_byte(8'h99, 1'b0, 1'b0);
    push_byte(8'h43, 1'b0, 1'b1);

    // All-wildcard pattern matches at offset zero.
    settle();
    write_length(2);
    load_entry(ENTRY_IDX_W'(0), 8'h00, 1'b1);
    load_entry(ENTRY_IDX_W'(1), 8'hFF, 1'b1);
    push_byte(8'h55, 1'b1, 1'b0);
    push_byte(8'h66, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b1);

    // Random phases rotate through the idling patterns; the first few
    // phases take the extreme register settings.
    sent_items = 0;
    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      case ((phase / 2) % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      settle();
      case (phase)
        0: len = 0;
        1: len = PATTERN_MAX;
        2: len = 127;
        3: len = PATTERN_MAX + 1;
        4: len = 1;
        default: len = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
      endcase
      write_length(len);
      n = effective_length(len);
      load_pattern(n, (phase % 6 == 5) ? 100 : 25);
      repeat ($urandom_range(3, 8)) run_region(n);
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("wildcard_byte_pattern_search_core test passed");
    end else begin
      $display("wildcard_byte_pattern_search_core test failed");
    end
    $finish;
  end

endmodule
